[src/pbm_pkg.sv]
// Package for the pixel blend mode unit: channel width, pipeline widths,
// blend mode codes and the item and divider request types.
// No dependencies.
`timescale 1ns / 1ps

package pbm_pkg;

    localparam int CH_BITS    = 16;
    localparam int FIELD_BITS = 16;
    localparam int QB         = CH_BITS + 1;
    localparam int WD         = 2 * CH_BITS;
    localparam int WN         = 3 * CH_BITS;
    localparam int WR         = WN + 2;

    typedef logic [CH_BITS-1:0] ch_t;
    typedef logic [QB-1:0]      quo_t;
    typedef logic [4:0]         mode_t;

    localparam ch_t CH_MAX = {CH_BITS{1'b1}};

    localparam mode_t MODE_NORMAL        = 5'd0;
    localparam mode_t MODE_MULTIPLY      = 5'd1;
    localparam mode_t MODE_SCREEN        = 5'd2;
    localparam mode_t MODE_OVERLAY       = 5'd3;
    localparam mode_t MODE_ADDITIVE      = 5'd4;
    localparam mode_t MODE_SOFT_LIGHT    = 5'd5;
    localparam mode_t MODE_DARKEN        = 5'd6;
    localparam mode_t MODE_LIGHTEN       = 5'd7;
    localparam mode_t MODE_COLOR_DODGE   = 5'd8;
    localparam mode_t MODE_COLOR_BURN    = 5'd9;
    localparam mode_t MODE_HARD_LIGHT    = 5'd10;
    localparam mode_t MODE_DIFFERENCE    = 5'd11;
    localparam mode_t MODE_EXCLUSION     = 5'd12;
    localparam mode_t MODE_LINEAR_DODGE  = 5'd13;
    localparam mode_t MODE_SUBTRACT      = 5'd14;
    localparam mode_t MODE_DIVIDE        = 5'd15;
    localparam mode_t MODE_LINEAR_BURN   = 5'd16;
    localparam mode_t MODE_VIVID_LIGHT   = 5'd17;
    localparam mode_t MODE_LINEAR_LIGHT  = 5'd18;
    localparam mode_t MODE_PIN_LIGHT     = 5'd19;
    localparam mode_t MODE_HARD_MIX      = 5'd20;
    localparam mode_t MODE_DARKER_COLOR  = 5'd21;
    localparam mode_t MODE_LIGHTER_COLOR = 5'd22;
    localparam mode_t MODE_LAST          = MODE_LIGHTER_COLOR;

    typedef struct packed {
        mode_t     mode;
        ch_t [2:0] s;
        ch_t [2:0] d;
        ch_t       sa;
        ch_t       da;
    } item_t;

    typedef struct packed {
        logic [WN-1:0] n;
        logic [WD-1:0] dv;
    } divop_t;

endpackage

[src/pbm_isqrt.sv]
// Pipelined floor square root of d*max for the three color channels,
// one root bit per stage. Carries the pixel item alongside.
// Depends on pbm_pkg.
`timescale 1ns / 1ps

module pbm_isqrt (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_vld,
    input  pbm_pkg::item_t        in_item,
    output logic                  out_vld,
    output pbm_pkg::item_t        out_item,
    output pbm_pkg::ch_t [2:0]    out_root
);
    import pbm_pkg::*;

    localparam int WV = 2 * CH_BITS;

    logic          vld_reg  [CH_BITS];
    item_t         item_reg [CH_BITS];
    logic [WV-1:0] rem_reg  [CH_BITS][3];
    ch_t           root_reg [CH_BITS][3];

    genvar j, c;
    generate
        for (j = 0; j < CH_BITS; j++) begin : g_stage
            localparam int K = CH_BITS - 1 - j;
            logic  vld_prev;
            item_t item_prev;

            if (j == 0) begin : g_first
                assign vld_prev  = in_vld;
                assign item_prev = in_item;
            end else begin : g_rest
                assign vld_prev  = vld_reg[j-1];
                assign item_prev = item_reg[j-1];
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[j] <= 1'b0;
                end else if (en) begin
                    vld_reg[j] <= vld_prev;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    item_reg[j] <= item_prev;
                end
            end

            for (c = 0; c < 3; c++) begin : g_ch
                logic [WV-1:0] rem_prev;
                logic [WV-1:0] rem_next;
                ch_t           root_prev;
                ch_t           root_next;
                logic [WV:0]   trial;
                logic          fits;

                if (j == 0) begin : g_first
                    assign rem_prev  = {in_item.d[c], {CH_BITS{1'b0}}} - WV'(in_item.d[c]);
                    assign root_prev = '0;
                end else begin : g_rest
                    assign rem_prev  = rem_reg[j-1][c];
                    assign root_prev = root_reg[j-1][c];
                end

                assign trial     = ((WV+1)'(root_prev) << (K + 1)) + ((WV+1)'(1) << (2 * K));
                assign fits      = {1'b0, rem_prev} >= trial;
                assign rem_next  = fits ? (rem_prev - trial[WV-1:0]) : rem_prev;
                assign root_next = fits ? (root_prev | (ch_t'(1) << K)) : root_prev;

                always_ff @(posedge aclk) begin
                    if (en) begin
                        rem_reg[j][c]  <= rem_next;
                        root_reg[j][c] <= root_next;
                    end
                end
            end
        end

        for (c = 0; c < 3; c++) begin : g_out
            assign out_root[c] = root_reg[CH_BITS-1][c];
        end
    endgenerate

    assign out_vld  = vld_reg[CH_BITS-1];
    assign out_item = item_reg[CH_BITS-1];

endmodule

[src/pbm_prep.sv]
// Three product stages that build the dividend and divisor of each color
// channel and of alpha for the selected blend mode.
// Depends on pbm_pkg.
`timescale 1ns / 1ps

module pbm_prep (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_vld,
    input  pbm_pkg::item_t         in_item,
    input  pbm_pkg::ch_t [2:0]     in_root,
    output logic                   out_vld,
    output pbm_pkg::item_t         out_item,
    output pbm_pkg::divop_t [3:0]  out_ops
);
    import pbm_pkg::*;

    localparam logic [CH_BITS:0] MAX_EXT = {1'b0, CH_MAX};
    localparam logic [WD-1:0]    MAX_D   = WD'(CH_MAX);
    localparam logic [WD-1:0]    MAX_SQ  = WD'(MAX_D * MAX_D);

    function automatic logic [WN-1:0] times_m(input logic [WD-1:0] x);
        return (WN'(x) << CH_BITS) - WN'(x);
    endfunction

    // stage 1
    logic          p1_vld_reg;
    item_t         p1_item_reg;
    logic [WD-1:0] p1_mult1_reg [3];
    logic [WD-1:0] p1_mult2_reg [3];
    ch_t           p1_c3_reg    [3];
    logic [WD-1:0] p1_am_reg;
    logic [WD-1:0] p1_mult1_next [3];
    logic [WD-1:0] p1_mult2_next [3];
    ch_t           p1_c3_next    [3];
    logic [WD-1:0] p1_am_next;

    always_comb begin
        ch_t              s;
        ch_t              d;
        ch_t              tt;
        ch_t              a1;
        ch_t              b1;
        ch_t              aa;
        ch_t              ab;
        logic [CH_BITS:0] two_s;
        logic [CH_BITS:0] two_d;
        logic [CH_BITS:0] hs;
        logic [CH_BITS:0] ls;
        for (int c = 0; c < 3; c++) begin
            s     = in_item.s[c];
            d     = in_item.d[c];
            tt    = (in_root[c] > d) ? in_root[c] : d;
            two_s = {s, 1'b0};
            two_d = {d, 1'b0};
            hs    = two_s - MAX_EXT;
            ls    = MAX_EXT - two_s;
            a1    = s;
            b1    = in_item.sa;
            case (in_item.mode)
                MODE_MULTIPLY, MODE_SCREEN, MODE_EXCLUSION: begin
                    a1 = s;
                    b1 = d;
                end
                MODE_OVERLAY: begin
                    a1 = (two_d < MAX_EXT) ? s : (CH_MAX - s);
                    b1 = (two_d < MAX_EXT) ? d : (CH_MAX - d);
                end
                MODE_HARD_LIGHT: begin
                    a1 = (two_s < MAX_EXT) ? s : (CH_MAX - s);
                    b1 = (two_s < MAX_EXT) ? d : (CH_MAX - d);
                end
                MODE_SOFT_LIGHT: begin
                    if (two_s <= MAX_EXT) begin
                        a1 = d;
                        b1 = CH_MAX - d;
                    end else begin
                        a1 = hs[CH_BITS-1:0];
                        b1 = tt - d;
                    end
                end
                default: begin
                    a1 = s;
                    b1 = in_item.sa;
                end
            endcase
            p1_mult1_next[c] = WD'(a1) * WD'(b1);
            p1_mult2_next[c] = WD'(d) * WD'(in_item.da);
            p1_c3_next[c]    = (in_item.mode == MODE_SOFT_LIGHT) ? ls[CH_BITS-1:0]
                                                                 : (CH_MAX - in_item.sa);
        end
        case (in_item.mode)
            MODE_MULTIPLY, MODE_SCREEN: begin
                aa = in_item.sa;
                ab = in_item.da;
            end
            MODE_HARD_LIGHT: begin
                aa = in_item.sa;
                ab = CH_MAX - in_item.da;
            end
            default: begin
                aa = in_item.da;
                ab = CH_MAX - in_item.sa;
            end
        endcase
        p1_am_next = WD'(aa) * WD'(ab);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
        end else if (en) begin
            p1_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_item_reg <= in_item;
            p1_am_reg   <= p1_am_next;
            for (int c = 0; c < 3; c++) begin
                p1_mult1_reg[c] <= p1_mult1_next[c];
                p1_mult2_reg[c] <= p1_mult2_next[c];
                p1_c3_reg[c]    <= p1_c3_next[c];
            end
        end
    end

    // stage 2
    logic          p2_vld_reg;
    item_t         p2_item_reg;
    logic [WD-1:0] p2_mult1_reg [3];
    logic [WN-1:0] p2_mult3_reg [3];
    logic [WD-1:0] p2_am_reg;
    logic [WN-1:0] p2_mult3_next [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            p2_mult3_next[c] = WN'((p1_item_reg.mode == MODE_SOFT_LIGHT) ? p1_mult1_reg[c]
                                                                       : p1_mult2_reg[c])
                             * WN'(p1_c3_reg[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_vld_reg <= 1'b0;
        end else if (en) begin
            p2_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_item_reg <= p1_item_reg;
            p2_am_reg   <= p1_am_reg;
            for (int c = 0; c < 3; c++) begin
                p2_mult1_reg[c] <= p1_mult1_reg[c];
                p2_mult3_reg[c] <= p2_mult3_next[c];
            end
        end
    end

    // stage 3
    logic   p3_vld_reg;
    item_t  p3_item_reg;
    divop_t p3_ops_reg  [4];
    divop_t p3_ops_next [4];

    always_comb begin
        ch_t              s;
        ch_t              d;
        logic [CH_BITS:0] two_s;
        logic [WD-1:0]    nd;
        for (int c = 0; c < 3; c++) begin
            s     = p2_item_reg.s[c];
            d     = p2_item_reg.d[c];
            two_s = {s, 1'b0};
            nd    = WD'(times_m(WD'(p2_item_reg.sa))) + p2_am_reg;
            p3_ops_next[c].n  = '0;
            p3_ops_next[c].dv = MAX_D;
            case (p2_item_reg.mode)
                MODE_MULTIPLY, MODE_SCREEN: begin
                    p3_ops_next[c].n = WN'(p2_mult1_reg[c]);
                end
                MODE_OVERLAY, MODE_HARD_LIGHT, MODE_EXCLUSION: begin
                    p3_ops_next[c].n = WN'(p2_mult1_reg[c]) << 1;
                end
                MODE_SOFT_LIGHT: begin
                    if (two_s <= MAX_EXT) begin
                        p3_ops_next[c].n  = p2_mult3_reg[c];
                        p3_ops_next[c].dv = MAX_SQ;
                    end else begin
                        p3_ops_next[c].n  = WN'(p2_mult1_reg[c]);
                    end
                end
                MODE_COLOR_DODGE: begin
                    p3_ops_next[c].n  = times_m(WD'(d));
                    p3_ops_next[c].dv = WD'(CH_MAX - s);
                end
                MODE_COLOR_BURN: begin
                    p3_ops_next[c].n  = times_m(WD'(CH_MAX - d));
                    p3_ops_next[c].dv = WD'(s);
                end
                MODE_DIVIDE: begin
                    p3_ops_next[c].n  = times_m(WD'(s));
                    p3_ops_next[c].dv = WD'(d);
                end
                MODE_VIVID_LIGHT: begin
                    if (two_s <= MAX_EXT) begin
                        p3_ops_next[c].n  = times_m(WD'(CH_MAX - d));
                        p3_ops_next[c].dv = WD'(two_s);
                    end else begin
                        p3_ops_next[c].n  = times_m(WD'(d));
                        p3_ops_next[c].dv = WD'({CH_MAX - s, 1'b0});
                    end
                end
                MODE_NORMAL: begin
                    p3_ops_next[c].n  = times_m(p2_mult1_reg[c]) + p2_mult3_reg[c];
                    p3_ops_next[c].dv = nd;
                end
                default: begin
                    p3_ops_next[c].n  = '0;
                    p3_ops_next[c].dv = MAX_D;
                end
            endcase
        end
        p3_ops_next[3].n  = WN'(p2_am_reg);
        p3_ops_next[3].dv = MAX_D;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_vld_reg <= 1'b0;
        end else if (en) begin
            p3_vld_reg <= p2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_item_reg <= p2_item_reg;
            for (int l = 0; l < 4; l++) begin
                p3_ops_reg[l] <= p3_ops_next[l];
            end
        end
    end

    assign out_vld  = p3_vld_reg;
    assign out_item = p3_item_reg;
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            out_ops[l] = p3_ops_reg[l];
        end
    end

endmodule

[src/pbm_div.sv]
// Four-lane pipelined restoring divider, one quotient bit per stage.
// Quotients that do not fit come out as all ones. Depends on pbm_pkg.
`timescale 1ns / 1ps

module pbm_div (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_vld,
    input  pbm_pkg::item_t         in_item,
    input  pbm_pkg::divop_t [3:0]  in_ops,
    output logic                   out_vld,
    output pbm_pkg::item_t         out_item,
    output pbm_pkg::quo_t [3:0]    out_q
);
    import pbm_pkg::*;

    logic          vld_reg  [QB];
    item_t         item_reg [QB];
    logic [WN-1:0] rem_reg  [QB][4];
    logic [WD-1:0] dv_reg   [QB][4];
    quo_t          q_reg    [QB][4];
    logic          sat_reg  [QB][4];

    genvar j, l;
    generate
        for (j = 0; j < QB; j++) begin : g_stage
            localparam int K = QB - 1 - j;
            logic  vld_prev;
            item_t item_prev;

            if (j == 0) begin : g_first
                assign vld_prev  = in_vld;
                assign item_prev = in_item;
            end else begin : g_rest
                assign vld_prev  = vld_reg[j-1];
                assign item_prev = item_reg[j-1];
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[j] <= 1'b0;
                end else if (en) begin
                    vld_reg[j] <= vld_prev;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    item_reg[j] <= item_prev;
                end
            end

            for (l = 0; l < 4; l++) begin : g_lane
                logic [WN-1:0] rem_prev;
                logic [WD-1:0] dv_prev;
                quo_t          q_prev;
                logic          sat_prev;
                logic [WR-1:0] shifted;
                logic          fits;

                if (j == 0) begin : g_first
                    assign rem_prev = in_ops[l].n;
                    assign dv_prev  = in_ops[l].dv;
                    assign q_prev   = '0;
                    assign sat_prev = WR'(in_ops[l].n) >= (WR'(in_ops[l].dv) << QB);
                end else begin : g_rest
                    assign rem_prev = rem_reg[j-1][l];
                    assign dv_prev  = dv_reg[j-1][l];
                    assign q_prev   = q_reg[j-1][l];
                    assign sat_prev = sat_reg[j-1][l];
                end

                assign shifted = WR'(dv_prev) << K;
                assign fits    = WR'(rem_prev) >= shifted;

                always_ff @(posedge aclk) begin
                    if (en) begin
                        rem_reg[j][l] <= fits ? (rem_prev - shifted[WN-1:0]) : rem_prev;
                        dv_reg[j][l]  <= dv_prev;
                        q_reg[j][l]   <= fits ? (q_prev | (quo_t'(1) << K)) : q_prev;
                        sat_reg[j][l] <= sat_prev;
                    end
                end
            end
        end

        for (l = 0; l < 4; l++) begin : g_out
            assign out_q[l] = sat_reg[QB-1][l] ? '1 : q_reg[QB-1][l];
        end
    endgenerate

    assign out_vld  = vld_reg[QB-1];
    assign out_item = item_reg[QB-1];

endmodule

[src/pbm_finish.sv]
// Final per-mode selection, guards, saturation and alpha rule, into the
// output register. Depends on pbm_pkg.
`timescale 1ns / 1ps

module pbm_finish (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_vld,
    input  pbm_pkg::item_t       in_item,
    input  pbm_pkg::quo_t [3:0]  in_q,
    output logic                 out_vld,
    output pbm_pkg::ch_t [3:0]   out_px
);
    import pbm_pkg::*;

    typedef logic [CH_BITS+1:0] wide_t;

    localparam wide_t MAX_W = wide_t'(CH_MAX);

    function automatic ch_t sat_w(input wide_t v);
        return (v > MAX_W) ? CH_MAX : v[CH_BITS-1:0];
    endfunction

    function automatic ch_t min_m(input quo_t q);
        return (q > quo_t'(CH_MAX)) ? CH_MAX : q[CH_BITS-1:0];
    endfunction

    function automatic ch_t over_fin(input logic low, input quo_t q);
        ch_t r;
        if (low) begin
            r = min_m(q);
        end else if (q >= quo_t'(CH_MAX)) begin
            r = '0;
        end else begin
            r = CH_MAX - q[CH_BITS-1:0];
        end
        return r;
    endfunction

    function automatic ch_t mix_fin(input mode_t mode, input ch_t s, input ch_t d,
                                    input ch_t sa, input ch_t da, input quo_t q);
        wide_t ws;
        wide_t wd;
        wide_t w2s;
        wide_t sd;
        wide_t qq;
        wide_t tmp;
        ch_t   mq;
        ch_t   r;
        logic  low_s;
        ws    = wide_t'(s);
        wd    = wide_t'(d);
        w2s   = ws << 1;
        sd    = ws + wd;
        qq    = wide_t'(q);
        mq    = min_m(q);
        low_s = w2s <= MAX_W;
        tmp   = '0;
        case (mode)
            MODE_MULTIPLY: r = sat_w(qq);
            MODE_SCREEN: r = sat_w(sd - qq);
            MODE_OVERLAY: r = over_fin((wd << 1) < MAX_W, q);
            MODE_ADDITIVE, MODE_LINEAR_DODGE: r = sat_w(sd);
            MODE_SOFT_LIGHT: begin
                if (low_s) begin
                    tmp = wd - qq;
                    r   = (qq >= wd) ? '0 : tmp[CH_BITS-1:0];
                end else begin
                    r = sat_w(wd + qq);
                end
            end
            MODE_DARKEN: r = (s < d) ? s : d;
            MODE_LIGHTEN: r = (s > d) ? s : d;
            MODE_COLOR_DODGE: r = (d == '0) ? '0 : ((s == CH_MAX) ? CH_MAX : mq);
            MODE_COLOR_BURN: r = (d == CH_MAX) ? CH_MAX : ((s == '0) ? '0 : (CH_MAX - mq));
            MODE_HARD_LIGHT: r = over_fin(w2s < MAX_W, q);
            MODE_DIFFERENCE: r = (s > d) ? (s - d) : (d - s);
            MODE_EXCLUSION: r = (sd >= qq) ? sat_w(sd - qq) : '0;
            MODE_SUBTRACT: r = (d > s) ? (d - s) : '0;
            MODE_DIVIDE: r = (d != '0) ? mq : CH_MAX;
            MODE_LINEAR_BURN: begin
                tmp = sd - MAX_W;
                r   = (sd > MAX_W) ? tmp[CH_BITS-1:0] : '0;
            end
            MODE_VIVID_LIGHT: begin
                if (low_s) begin
                    r = (s == '0) ? '0 : (CH_MAX - mq);
                end else begin
                    r = (s == CH_MAX) ? CH_MAX : mq;
                end
            end
            MODE_LINEAR_LIGHT: begin
                tmp = wd + w2s;
                r   = (tmp > MAX_W) ? sat_w(tmp - MAX_W) : '0;
            end
            MODE_PIN_LIGHT: begin
                if (low_s) begin
                    r = (wd < w2s) ? d : w2s[CH_BITS-1:0];
                end else begin
                    tmp = w2s - MAX_W;
                    r   = (wd > tmp) ? d : tmp[CH_BITS-1:0];
                end
            end
            MODE_HARD_MIX: r = (sd >= MAX_W) ? CH_MAX : '0;
            default: r = ((sa == '0) && (da == '0)) ? '0 : sat_w(qq);
        endcase
        return r;
    endfunction

    logic       vld_reg;
    ch_t [3:0]  px_reg;
    ch_t [3:0]  px_next;

    always_comb begin
        ch_t   a;
        wide_t wsa;
        wide_t wda;
        wide_t ss;
        wide_t ds;
        logic  pick_src;
        wsa = wide_t'(in_item.sa);
        wda = wide_t'(in_item.da);
        case (in_item.mode)
            MODE_MULTIPLY: a = min_m(in_q[3]);
            MODE_SCREEN: a = sat_w(wsa + wda - wide_t'(in_q[3]));
            MODE_ADDITIVE: a = sat_w(wsa + wda);
            MODE_HARD_LIGHT: a = sat_w(wda + wide_t'(in_q[3]));
            default: a = sat_w(wsa + wide_t'(in_q[3]));
        endcase
        ss = wide_t'(in_item.s[0]) + wide_t'(in_item.s[1]) + wide_t'(in_item.s[2]);
        ds = wide_t'(in_item.d[0]) + wide_t'(in_item.d[1]) + wide_t'(in_item.d[2]);
        pick_src = (in_item.mode == MODE_DARKER_COLOR) ? (ss <= ds) : (ss >= ds);
        for (int c = 0; c < 3; c++) begin
            if ((in_item.mode == MODE_DARKER_COLOR) || (in_item.mode == MODE_LIGHTER_COLOR)) begin
                px_next[c] = pick_src ? in_item.s[c] : in_item.d[c];
            end else begin
                px_next[c] = mix_fin(in_item.mode, in_item.s[c], in_item.d[c],
                                     in_item.sa, in_item.da, in_q[c]);
            end
        end
        px_next[3] = a;
        if (((in_item.mode == MODE_NORMAL) || (in_item.mode == MODE_OVERLAY) ||
             (in_item.mode == MODE_HARD_LIGHT)) && (a == '0)) begin
            px_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg <= px_next;
        end
    end

    assign out_vld = vld_reg;
    assign out_px  = px_reg;

endmodule

[src/pixel_blend_mode_unit.sv]
// Pixel blend mode unit: source over destination RGBA blend, 23 modes.
// Pipeline: 16 square root stages, 3 product stages, 17 divider stages,
// then the output register. Throughput: one pixel per cycle; the whole
// pipeline advances whenever the output register is empty or being taken.
// Reset: synchronous active-low aresetn clears all valid bits and sets the
// blend mode to normal. Depends on pbm_pkg and the pbm_* stage modules.
`timescale 1ns / 1ps

module pixel_blend_mode_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // src_r, src_g, src_b, src_a, dst_r, dst_g, dst_b, dst_a (16 bits each)
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_r, out_g, out_b, out_alpha (16 bits each)
    output logic [63:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [4:0]   cfg_data
);
    import pbm_pkg::*;

    mode_t mode_reg;
    logic  en;
    item_t in_item;

    logic             sq_vld;
    item_t            sq_item;
    ch_t [2:0]        sq_root;
    logic             pr_vld;
    item_t            pr_item;
    divop_t [3:0]     pr_ops;
    logic             dv_vld;
    item_t            dv_item;
    quo_t [3:0]       dv_q;
    ch_t [3:0]        px;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
        end else if (cfg_valid && cfg_ready) begin
            mode_reg <= cfg_data;
        end
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_comb begin
        in_item.mode = (mode_reg > MODE_LAST) ? MODE_NORMAL : mode_reg;
        for (int c = 0; c < 3; c++) begin
            in_item.s[c] = s_tdata[FIELD_BITS*c +: CH_BITS];
            in_item.d[c] = s_tdata[FIELD_BITS*(4+c) +: CH_BITS];
        end
        in_item.sa = s_tdata[FIELD_BITS*3 +: CH_BITS];
        in_item.da = s_tdata[FIELD_BITS*7 +: CH_BITS];
    end

    pbm_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (s_tvalid),
        .in_item  (in_item),
        .out_vld  (sq_vld),
        .out_item (sq_item),
        .out_root (sq_root)
    );

    pbm_prep u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (sq_vld),
        .in_item  (sq_item),
        .in_root  (sq_root),
        .out_vld  (pr_vld),
        .out_item (pr_item),
        .out_ops  (pr_ops)
    );

    pbm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (pr_vld),
        .in_item  (pr_item),
        .in_ops   (pr_ops),
        .out_vld  (dv_vld),
        .out_item (dv_item),
        .out_q    (dv_q)
    );

    pbm_finish u_finish (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (dv_vld),
        .in_item  (dv_item),
        .in_q     (dv_q),
        .out_vld  (m_tvalid),
        .out_px   (px)
    );

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            m_tdata[FIELD_BITS*i +: FIELD_BITS] = FIELD_BITS'(px[i]);
        end
    end

endmodule
